/* hdl/hsvc_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
// Depends on nothing; imported by hsvc_term and hsv_to_rgb_converter.
`default_nettype none

package hsvc_pkg;

  // Saturation and value are carried in thousandths.
  typedef logic [9:0] unit_t;
  // Hue sector number, hue div 60 (0 to 8 for a 9-bit hue).
  typedef logic [3:0] sector_t;
  // Offset inside a sector, hue mod 60.
  typedef logic [5:0] deg_t;
  // One 8-bit color channel.
  typedef logic [7:0] chan_t;

  localparam unit_t FULL_SCALE = 10'd1000;
  localparam deg_t  SECTOR_DEG = 6'd60;
  // 60 * 1000, the span of s * k.
  localparam logic [15:0] SPAN = 16'd60000;

  // hue div 60 as (hue * 1093) >> 16, exact for every 9-bit hue.
  localparam logic [10:0] DIV60_MUL   = 11'd1093;
  localparam int          DIV60_SHIFT = 16;

  // Channel = floor(x * 255 / 60e6) = floor(floor(x * 17 / 256) / 15625).
  // The last division is a multiply by ceil(2^36 / 15625) and a shift,
  // exact for every quotient input below 4.0e6.
  localparam logic [22:0] RECIP_MUL   = 23'd4398047;
  localparam int          RECIP_SHIFT = 36;

  // Sectors; five and above all use the last formula set.
  localparam sector_t SEC_RED_YEL   = 4'd0;
  localparam sector_t SEC_YEL_GRN   = 4'd1;
  localparam sector_t SEC_GRN_CYN   = 4'd2;
  localparam sector_t SEC_CYN_BLU   = 4'd3;
  localparam sector_t SEC_BLU_MAG   = 4'd4;

endpackage

`default_nettype wire

/* hdl/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB converter: hue split, four channel terms, sector select.
// Depends on hsvc_pkg and hsvc_term.
//
//   channel | ports                                           | direction
//   input   | start, busy, in_hue, in_saturation, in_brightness | in, busy out
//   result  | out_valid, out_red, out_green, out_blue           | out
//
// One pixel is taken in every cycle while busy is low; busy is high only in reset.
// Each result appears for one cycle, with out_valid, after its pixel passes every stage.
// Depth comes from the stages: hue div 60, remainder, s * k, v * (60000 - s * k),
// the reciprocal multiply and the output register, each a register stage of its own.
// Reset clears the valid bits only; data registers run free.
// The receiver cannot stall, so no stage ever holds.
`default_nettype none

module hsv_to_rgb_converter
  import hsvc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  start,
  output logic       busy,
  input  wire logic [8:0] in_hue,
  input  wire unit_t in_saturation,
  input  wire unit_t in_brightness,
  output logic       out_valid,
  output chan_t      out_red,
  output chan_t      out_green,
  output chan_t      out_blue
);

  logic        accept;
  logic [4:0]  vld_r, vld_nxt;
  unit_t       sat_c, bri_c;
  logic [19:0] sec_prod;

  logic [8:0]  hue1_r;
  sector_t     sec1_r, sec2_r, sec3_r, sec4_r, sec5_r;
  unit_t       sat1_r, bri1_r, sat2_r, bri2_r;
  logic [9:0]  sec_x60, rem_w;
  deg_t        rem2_r, remc2_r;

  chan_t       cv, cp, cq, ct;
  chan_t       red_nxt, green_nxt, blue_nxt;
  logic        out_valid_r;
  chan_t       red_r, green_r, blue_r;

  assign busy   = !rst_n;
  assign accept = start && !busy;

  // Valid bits travel alongside the data stages.
  assign vld_nxt = {vld_r[3:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[4];
    end
  end

  // Stage one: clamp s and v, find the sector by reciprocal multiply.
  assign sat_c    = (in_saturation > FULL_SCALE) ? FULL_SCALE : in_saturation;
  assign bri_c    = (in_brightness > FULL_SCALE) ? FULL_SCALE : in_brightness;
  assign sec_prod = 20'(in_hue) * 20'(DIV60_MUL);

  // Stage two: remainder inside the sector and its complement.
  assign sec_x60 = {sec1_r, 6'b000000} - {4'b0000, sec1_r, 2'b00};
  assign rem_w   = {1'b0, hue1_r} - sec_x60;

  always_ff @(posedge clk) begin
    hue1_r  <= in_hue;
    sec1_r  <= sec_prod[DIV60_SHIFT +: 4];
    sat1_r  <= sat_c;
    bri1_r  <= bri_c;
    sec2_r  <= sec1_r;
    sat2_r  <= sat1_r;
    bri2_r  <= bri1_r;
    rem2_r  <= rem_w[5:0];
    remc2_r <= SECTOR_DEG - rem_w[5:0];
    sec3_r  <= sec2_r;
    sec4_r  <= sec3_r;
    sec5_r  <= sec4_r;
  end

  // The four candidate channel values v, p, q and t.
  hsvc_term u_term_v (.clk(clk), .sat(sat2_r), .bri(bri2_r), .k(6'd0),       .chan(cv));
  hsvc_term u_term_p (.clk(clk), .sat(sat2_r), .bri(bri2_r), .k(SECTOR_DEG), .chan(cp));
  hsvc_term u_term_q (.clk(clk), .sat(sat2_r), .bri(bri2_r), .k(rem2_r),     .chan(cq));
  hsvc_term u_term_t (.clk(clk), .sat(sat2_r), .bri(bri2_r), .k(remc2_r),    .chan(ct));

  // Six-sector selection; sector five and beyond share one formula set.
  always_comb begin
    case (sec5_r)
      SEC_RED_YEL: begin
        red_nxt = cv; green_nxt = ct; blue_nxt = cp;
      end
      SEC_YEL_GRN: begin
        red_nxt = cq; green_nxt = cv; blue_nxt = cp;
      end
      SEC_GRN_CYN: begin
        red_nxt = cp; green_nxt = cv; blue_nxt = ct;
      end
      SEC_CYN_BLU: begin
        red_nxt = cp; green_nxt = cq; blue_nxt = cv;
      end
      SEC_BLU_MAG: begin
        red_nxt = ct; green_nxt = cp; blue_nxt = cv;
      end
      default: begin
        red_nxt = cv; green_nxt = cp; blue_nxt = cq;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  // A result only ever follows a matching transfer.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 6))
    else $error("result without a matching transfer");

  // Zero saturation gives a gray pixel.
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_saturation, 6) == 10'd0) |->
      (out_red == out_green && out_green == out_blue))
    else $error("zero saturation did not give gray");

  // In the first sector red leads, then green, then blue.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_hue, 6) < 9'd60) |->
      (out_red >= out_green && out_green >= out_blue))
    else $error("channel order wrong in first sector");

endmodule

`default_nettype wire

/* hdl/hsvc_term.sv */
// One channel term v * (60000 - s * k) * 255 / 60e6, floored, in three stages.
// Depends on hsvc_pkg for types and scaling constants.
`default_nettype none

module hsvc_term
  import hsvc_pkg::*;
(
  input  wire logic  clk,
  input  wire unit_t sat,
  input  wire unit_t bri,
  input  wire deg_t  k,
  output chan_t      chan
);

  logic [15:0] sk_r, sk_nxt;
  unit_t       bri_r;
  logic [25:0] x_r, x_nxt;
  logic [15:0] diff;
  logic [30:0] y;
  logic [22:0] z;
  logic [45:0] p_r, p_nxt;

  // Stage one: the product s * k, at most 60000 with s clamped.
  assign sk_nxt = 16'(sat) * 16'(k);

  // Stage two: scale the complement by the brightness.
  assign diff  = SPAN - sk_r;
  assign x_nxt = 26'(bri_r) * 26'(diff);

  // Stage three: times 17, drop eight bits, then the reciprocal of 15625.
  assign y     = {1'b0, x_r, 4'b0000} + 31'(x_r);
  assign z     = y[30:8];
  assign p_nxt = 46'(z) * 46'(RECIP_MUL);

  always_ff @(posedge clk) begin
    sk_r  <= sk_nxt;
    bri_r <= bri;
    x_r   <= x_nxt;
    p_r   <= p_nxt;
  end

  assign chan = p_r[RECIP_SHIFT +: 8];

endmodule

`default_nettype wire

/* tb/tb_hsv_to_rgb_converter.sv */
// Self-checking testbench for hsv_to_rgb_converter: directed corner pixels, then random ones.
// Depends on hsvc_pkg and the converter RTL; a small scoreboard class predicts every pixel.
`timescale 1ns / 1ps

import hsvc_pkg::*;

typedef struct packed {
  chan_t red;
  chan_t green;
  chan_t blue;
} rgb_t;

// Predicts the color of each accepted pixel and compares the converter's results in order.
class rgb_scoreboard;
  rgb_t expected_rgb[$];
  int   mismatches;

  function new();
    mismatches = 0;
  endfunction

  // One channel term: floor(v * (60000 - s * k) * 255 / 60e6).
  function automatic longint unsigned hsv_term(longint unsigned v, longint unsigned s,
                                               longint unsigned k);
    longint unsigned num;
    num = v * (64'd60000 - s * k);
    return (num * 64'd255) / 64'd60000000;
  endfunction

  function automatic rgb_t predict_rgb(logic [8:0] hue, unit_t sat, unit_t bri);
    longint unsigned s, v, sector, rem, cv, cp, cq, ct;
    rgb_t c;
    s = (sat > FULL_SCALE) ? 64'd1000 : 64'(sat);
    v = (bri > FULL_SCALE) ? 64'd1000 : 64'(bri);
    sector = 64'(hue) / 64'd60;
    rem = 64'(hue) % 64'd60;
    cv = hsv_term(v, s, 0);
    cp = hsv_term(v, s, 60);
    cq = hsv_term(v, s, rem);
    ct = hsv_term(v, s, 64'd60 - rem);
    // Six-sector table; hue 360 and above falls into the last formula set.
    case (sector)
      64'(SEC_RED_YEL): c = '{chan_t'(cv), chan_t'(ct), chan_t'(cp)};
      64'(SEC_YEL_GRN): c = '{chan_t'(cq), chan_t'(cv), chan_t'(cp)};
      64'(SEC_GRN_CYN): c = '{chan_t'(cp), chan_t'(cv), chan_t'(ct)};
      64'(SEC_CYN_BLU): c = '{chan_t'(cp), chan_t'(cq), chan_t'(cv)};
      64'(SEC_BLU_MAG): c = '{chan_t'(ct), chan_t'(cp), chan_t'(cv)};
      default:          c = '{chan_t'(cv), chan_t'(cp), chan_t'(cq)};
    endcase
    return c;
  endfunction

  function void note_pixel(logic [8:0] hue, unit_t sat, unit_t bri);
    expected_rgb.push_back(predict_rgb(hue, sat, bri));
  endfunction

  // Prints one line per mismatch and counts it.
  task report_mismatch(string what, int got, int want);
    mismatches++;
    $display("error at %0t: %s got %0d, want %0d", $realtime, what, got, want);
  endtask

  task check_pixel(chan_t red, chan_t green, chan_t blue);
    rgb_t want;
    if (expected_rgb.size() == 0) begin
      report_mismatch("result with no pixel pending, red", red, -1);
    end else begin
      want = expected_rgb.pop_front();
      if (red !== want.red) report_mismatch("red", red, want.red);
      if (green !== want.green) report_mismatch("green", green, want.green);
      if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
    end
  endtask

  function int pending();
    return expected_rgb.size();
  endfunction
endclass

module tb_hsv_to_rgb_converter;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PIXELS = 1030;
  localparam int DRAIN_CYCLES = 24;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [8:0]  in_hue = '0;
  unit_t       in_saturation = '0;
  unit_t       in_brightness = '0;
  logic        out_valid;
  chan_t       out_red;
  chan_t       out_green;
  chan_t       out_blue;

  int          cycle_count = 0;
  bit          burst_mode = 1'b0;
  rgb_scoreboard sb = new();

  hsv_to_rgb_converter uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue)
  );

  // 4 ns clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hsv_to_rgb_converter: mismatch");
      $finish;
    end
  end

  // Every strobed result is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_pixel(out_red, out_green, out_blue);
    end
  end

  // Drives one pixel after an optional idle gap and holds it until the transfer.
  task automatic send_pixel(logic [8:0] hue, unit_t sat, unit_t bri);
    int  gap;
    bit  was_busy;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_hue <= hue;
    in_saturation <= sat;
    in_brightness <= bri;
    // Busy only moves at rising edges, so its mid-cycle value is the one the edge sees.
    do begin
      @(negedge clk);
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
    sb.note_pixel(hue, sat, bri);
  endtask

  // Mostly in-range values, with extremes and out-of-range codes mixed in.
  function automatic unit_t pick_unit();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return ($urandom_range(0, 1) != 0) ? FULL_SCALE : unit_t'(0);
    if (roll < 20) return unit_t'($urandom_range(0, 1023));
    return unit_t'($urandom_range(0, 1000));
  endfunction

  initial begin
    logic [8:0] h;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: sector edges, hue 360 and above, zero and clamped saturation/value.
    burst_mode = 1'b1;
    send_pixel(9'd0, 10'd0, 10'd0);
    send_pixel(9'd0, 10'd1000, 10'd1000);
    send_pixel(9'd59, 10'd1000, 10'd1000);
    send_pixel(9'd60, 10'd1000, 10'd1000);
    send_pixel(9'd120, 10'd1000, 10'd1000);
    send_pixel(9'd180, 10'd1000, 10'd1000);
    send_pixel(9'd240, 10'd1000, 10'd1000);
    send_pixel(9'd300, 10'd1000, 10'd500);
    send_pixel(9'd359, 10'd1000, 10'd1000);
    send_pixel(9'd360, 10'd1000, 10'd1000);
    send_pixel(9'd360, 10'd400, 10'd733);
    send_pixel(9'd361, 10'd1000, 10'd1000);
    send_pixel(9'd420, 10'd777, 10'd999);
    send_pixel(9'd479, 10'd250, 10'd1000);
    send_pixel(9'd511, 10'd1023, 10'd1023);
    send_pixel(9'd200, 10'd0, 10'd1000);
    send_pixel(9'd90, 10'd0, 10'd333);
    send_pixel(9'd45, 10'd1001, 10'd600);
    send_pixel(9'd150, 10'd700, 10'd1001);
    send_pixel(9'd330, 10'd1023, 10'd0);
    burst_mode = 1'b0;
    send_pixel(9'd1, 10'd1, 10'd1);
    send_pixel(9'd270, 10'd512, 10'd511);

    // Random part, switching between idle gaps and back-to-back stretches.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 85) begin
        h = 9'($urandom_range(0, 360));
      end else begin
        h = 9'($urandom_range(0, 511));
      end
      send_pixel(h, pick_unit(), pick_unit());
    end
    start <= 1'b0;

    // Drain the pipeline, then allow a few more cycles for stray results.
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("hsv_to_rgb_converter: match");
    end else begin
      $display("hsv_to_rgb_converter: mismatch");
    end
    $finish;
  end
endmodule
